// ----- sv/ylr_pkg.sv -----
// ----------------------------------------------------------------------------
// ylr_pkg
// Shared types, constants and constant tables of the YUV to linear RGB core:
// the BT.709 matrix coefficients in Q12 and the Q30 sRGB decoding tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ylr_pkg;

   localparam int DEFAULT_OUT_BITS = 16;
   localparam int FIELD_W   = 16;
   localparam int PIXEL_W   = 8;
   localparam int CODE_W    = 12;
   localparam int ACC_W     = 24;
   localparam int Q30_FRAC  = 30;
   localparam int LEVEL_W   = 31;

   localparam logic signed [ACC_W-1:0] COEF_RV = 24'sd6450;
   localparam logic signed [ACC_W-1:0] COEF_GU = 24'sd767;
   localparam logic signed [ACC_W-1:0] COEF_GV = 24'sd1917;
   localparam logic signed [ACC_W-1:0] COEF_BU = 24'sd7601;
   localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 24'sd128;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sd1044480;
   localparam logic signed [ACC_W-1:0] ACC_ROUND = 24'sd128;

   localparam logic [CODE_W-1:0] LIN_LIMIT = 12'd165;

   localparam logic [63:0] GAMMA_DEN = 64'd269025;
   localparam logic [63:0] LINEAR_DEN = 64'd5271360;
   localparam logic [63:0] Q30_ONE = 64'd1 << Q30_FRAC;

   typedef logic [LEVEL_W-1:0] q30_type;
   typedef q30_type q30_table_type [256];

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } ylr_stage_en_type;

   function automatic logic [63:0] pow5_q30(input logic [63:0] y);
      logic [63:0] p;
      p = y;
      for (int n = 0; n < 4; n++) begin
         p = (p * y) >> Q30_FRAC;
      end
      return p;
   endfunction

   function automatic q30_table_type build_gamma_rom();
      q30_table_type rom;
      logic [63:0] num;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      for (int k = 0; k < 256; k++) begin
         num = (64'(1000 * k) + 64'd14025) << Q30_FRAC;
         x   = (num + GAMMA_DEN / 2) / GAMMA_DEN;
         x2  = (x * x + (Q30_ONE >> 1)) >> Q30_FRAC;
         lo  = 64'd0;
         hi  = Q30_ONE + 64'd1;
         for (int s = 0; s < 40; s++) begin
            if (hi - lo > 64'd1) begin
               mid = lo + ((hi - lo) >> 1);
               if (pow5_q30(mid) <= x2) begin
                  lo = mid;
               end else begin
                  hi = mid;
               end
            end
         end
         rom[k] = LEVEL_W'((x2 * lo + (Q30_ONE >> 1)) >> Q30_FRAC);
      end
      return rom;
   endfunction

   function automatic q30_table_type build_linear_table();
      q30_table_type tbl;
      for (int c = 0; c < 256; c++) begin
         tbl[c] = LEVEL_W'((64'(c) * 64'd100 * Q30_ONE + LINEAR_DEN / 2) / LINEAR_DEN);
      end
      return tbl;
   endfunction

   localparam q30_table_type GAMMA_ROM    = build_gamma_rom();
   localparam q30_table_type LINEAR_TABLE = build_linear_table();

endpackage

`default_nettype wire

// ----- sv/ylr_lane.sv -----
// ----------------------------------------------------------------------------
// ylr_lane
// One color channel of the transfer stages: table lookup, interpolation,
// scaling to the output range and rounding, in four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ylr_lane
   import ylr_pkg::*;
#(
   parameter int OUT_BITS = DEFAULT_OUT_BITS
) (
   input  wire logic                clock,
   input  wire ylr_stage_en_type    stage_en,
   input  wire logic [CODE_W-1:0]   code,
   output logic      [FIELD_W-1:0]  level_out
);

   localparam int PROD_W = LEVEL_W + OUT_BITS;
   localparam int SUM_W  = (PROD_W + 1 > Q30_FRAC + FIELD_W) ? PROD_W + 1 : Q30_FRAC + FIELD_W;
   localparam logic [PROD_W-1:0] SCALE = (PROD_W'(1) << OUT_BITS) - PROD_W'(1);
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (Q30_FRAC - 1);

   logic [7:0]         idx_lo;
   logic [7:0]         idx_hi;
   q30_type            rom_a;
   q30_type            rom_b;

   q30_type            base_ff;
   q30_type            base_in;
   q30_type            delta_ff;
   q30_type            delta_in;
   q30_type            lin_ff;
   q30_type            lin_in;
   logic [3:0]         frac_ff;
   logic [3:0]         frac_in;
   logic               sel_lin_ff;
   logic               sel_lin_in;

   logic [LEVEL_W+3:0] step;
   q30_type            level_ff;
   q30_type            level_in;

   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;

   logic [SUM_W-1:0]   rounded;
   logic [FIELD_W-1:0] out_ff;
   logic [FIELD_W-1:0] out_in;

   always_comb begin
      idx_lo     = code[CODE_W-1:4];
      idx_hi     = (idx_lo == 8'hFF) ? idx_lo : idx_lo + 8'd1;
      rom_a      = GAMMA_ROM[idx_lo];
      rom_b      = GAMMA_ROM[idx_hi];
      base_in    = rom_a;
      delta_in   = (rom_b >= rom_a) ? rom_b - rom_a : '0;
      frac_in    = code[3:0];
      sel_lin_in = (code <= LIN_LIMIT);
      lin_in     = LINEAR_TABLE[code[7:0]];
   end

   always_comb begin
      step     = (LEVEL_W+4)'(delta_ff) * (LEVEL_W+4)'(frac_ff) + (LEVEL_W+4)'(8);
      level_in = sel_lin_ff ? lin_ff : base_ff + LEVEL_W'(step >> 4);
      prod_in  = PROD_W'(level_ff) * SCALE;
      rounded  = SUM_W'(prod_ff) + ROUND_HALF;
      out_in   = rounded[Q30_FRAC +: FIELD_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         base_ff    <= base_in;
         delta_ff   <= delta_in;
         lin_ff     <= lin_in;
         frac_ff    <= frac_in;
         sel_lin_ff <= sel_lin_in;
      end
      if (stage_en.s3) begin
         level_ff <= level_in;
      end
      if (stage_en.s4) begin
         prod_ff <= prod_in;
      end
      if (stage_en.s5) begin
         out_ff <= out_in;
      end
   end

   assign level_out = out_ff;

endmodule

`default_nettype wire

// ----- sv/yuv_to_linear_rgb_core.sv -----
// ----------------------------------------------------------------------------
// yuv_to_linear_rgb_core
// Full-range BT.709 YCbCr to linear-light RGB, one pixel per request.
// ----------------------------------------------------------------------------
// The core accepts one pixel per clock while its pipeline is not held, and
// each result passes its five register stages in order: the color
// matrix with clamping, the gamma table lookup, the interpolation, the scale
// to 2^OUT_BITS - 1 and the final rounding. The decoding tables are constant
// logic, so no setup is needed after reset. A stalled result holds the
// pipeline only where it is full, so empty stages keep taking requests.
`default_nettype none

module yuv_to_linear_rgb_core
   import ylr_pkg::*;
#(
   parameter int OUT_BITS = DEFAULT_OUT_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PIXEL_W-1:0]  req_luma,
   input  wire logic [PIXEL_W-1:0]  req_chroma_blue,
   input  wire logic [PIXEL_W-1:0]  req_chroma_red,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [FIELD_W-1:0]  rsp_red_linear,
   output logic      [FIELD_W-1:0]  rsp_green_linear,
   output logic      [FIELD_W-1:0]  rsp_blue_linear
);

   function automatic logic [CODE_W-1:0] to_q84(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      sum = acc + ACC_ROUND;
      if (acc < 0) begin
         return '0;
      end else if (acc > ACC_MAX) begin
         sum = ACC_MAX + ACC_ROUND;
      end
      return sum[8 +: CODE_W];
   endfunction

   logic [4:0]              valid_ff;
   logic [4:0]              valid_in;
   logic [4:0]              stage_ready;
   ylr_stage_en_type        stage_en;

   logic signed [ACC_W-1:0] y_s;
   logic signed [ACC_W-1:0] u_s;
   logic signed [ACC_W-1:0] v_s;
   logic signed [ACC_W-1:0] acc_r;
   logic signed [ACC_W-1:0] acc_g;
   logic signed [ACC_W-1:0] acc_b;

   logic [CODE_W-1:0]       code_r_ff;
   logic [CODE_W-1:0]       code_r_in;
   logic [CODE_W-1:0]       code_g_ff;
   logic [CODE_W-1:0]       code_g_in;
   logic [CODE_W-1:0]       code_b_ff;
   logic [CODE_W-1:0]       code_b_in;

   always_comb begin
      stage_ready[4] = !valid_ff[4] || rsp_ready;
      for (int k = 3; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < 5; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
      stage_en.s2 = stage_ready[1];
      stage_en.s3 = stage_ready[2];
      stage_en.s4 = stage_ready[3];
      stage_en.s5 = stage_ready[4];
   end

   always_comb begin
      y_s   = ACC_W'(req_luma);
      u_s   = ACC_W'(req_chroma_blue) - CHROMA_OFFSET;
      v_s   = ACC_W'(req_chroma_red) - CHROMA_OFFSET;
      acc_r = (y_s <<< 12) + COEF_RV * v_s;
      acc_g = (y_s <<< 12) - COEF_GU * u_s - COEF_GV * v_s;
      acc_b = (y_s <<< 12) + COEF_BU * u_s;
      code_r_in = to_q84(acc_r);
      code_g_in = to_q84(acc_g);
      code_b_in = to_q84(acc_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         code_r_ff <= code_r_in;
         code_g_ff <= code_g_in;
         code_b_ff <= code_b_in;
      end
   end

   ylr_lane #(.OUT_BITS(OUT_BITS)) u_lane_red (
      .clock     (clock),
      .stage_en  (stage_en),
      .code      (code_r_ff),
      .level_out (rsp_red_linear)
   );

   ylr_lane #(.OUT_BITS(OUT_BITS)) u_lane_green (
      .clock     (clock),
      .stage_en  (stage_en),
      .code      (code_g_ff),
      .level_out (rsp_green_linear)
   );

   ylr_lane #(.OUT_BITS(OUT_BITS)) u_lane_blue (
      .clock     (clock),
      .stage_en  (stage_en),
      .code      (code_b_ff),
      .level_out (rsp_blue_linear)
   );

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[4];

endmodule

`default_nettype wire

// ----- sv/ylr_checker.sv -----
// ----------------------------------------------------------------------------
// ylr_checker
// Port-level checks of the YUV to linear RGB core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ylr_checker
   import ylr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [FIELD_W-1:0]  rsp_red_linear,
   input wire logic [FIELD_W-1:0]  rsp_green_linear,
   input wire logic [FIELD_W-1:0]  rsp_blue_linear
);

   localparam logic [3:0] DEPTH = 4'd5;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;

   always_comb begin
      pending_in = pending_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_linear)
         && $stable(rsp_green_linear) && $stable(rsp_blue_linear))
      else $error("Stalled result changed or dropped.");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("Result shown with no request in flight.");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= DEPTH)
      else $error("More requests in flight than pipeline stages.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 4'd0 |-> req_ready)
      else $error("Empty pipeline refused a request.");

endmodule

bind yuv_to_linear_rgb_core ylr_checker u_ylr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_red_linear   (rsp_red_linear),
   .rsp_green_linear (rsp_green_linear),
   .rsp_blue_linear  (rsp_blue_linear)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YCbCr to linear-light RGB core.
// Every accepted request is run through a bench-side copy of the color
// matrix and the sRGB decoding curve. The expected levels are queued in
// order and compared field by field with each accepted result. Random gaps
// are put on both sides, and one long hold on the result side makes the
// core stall its input.
// ----------------------------------------------------------------------------

module tb_top
   import ylr_pkg::*;
;

   localparam int OUT_W         = 16;
   localparam int KNEE_CODE     = 165;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_PIXELS = 1700;
   localparam int MAX_REPORTS   = 100;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
   } linear_rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PIXEL_W-1:0] req_luma = '0;
   logic [PIXEL_W-1:0] req_chroma_blue = '0;
   logic [PIXEL_W-1:0] req_chroma_red = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_red_linear;
   logic [FIELD_W-1:0] rsp_green_linear;
   logic [FIELD_W-1:0] rsp_blue_linear;

   logic [63:0]    srgb_curve [256];
   linear_rgb_type expected_rgb [$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   bit             no_idle = 1'b0;
   bit             hold_pending = 1'b0;

   yuv_to_linear_rgb_core #(
      .OUT_BITS(OUT_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_luma(req_luma),
      .req_chroma_blue(req_chroma_blue),
      .req_chroma_red(req_chroma_red),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red_linear(rsp_red_linear),
      .rsp_green_linear(rsp_green_linear),
      .rsp_blue_linear(rsp_blue_linear)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] fifth_power(input logic [63:0] v);
      logic [63:0] prod;
      prod = v;
      for (int n = 0; n < 4; n++) begin
         prod = (prod * v) >> 30;
      end
      return prod;
   endfunction

   // Point k of the power segment: (k/255 + 0.055)/1.055 raised to 2.4, in Q30.
   function automatic logic [63:0] curve_point(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      x  = (((64'(1000 * k) + 64'd14025) << 30) + 64'd134512) / 64'd269025;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      lo = 64'd0;
      hi = (64'd1 << 30) + 64'd1;
      while (hi - lo > 64'd1) begin
         mid = lo + ((hi - lo) >> 1);
         if (fifth_power(mid) <= x2) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return (x2 * lo + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [11:0] gamma_code(input int acc);
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > 255 * 4096) begin
         acc = 255 * 4096;
      end
      return 12'((acc + 128) >> 8);
   endfunction

   function automatic logic [FIELD_W-1:0] decode_level(input logic [11:0] code);
      logic [63:0] lin;
      logic [63:0] lo_pt;
      logic [63:0] hi_pt;
      logic [63:0] span;
      int          seg;
      int          nxt;
      if (code <= KNEE_CODE) begin
         lin = (64'(code) * 64'd100 * (64'd1 << 30) + 64'd2635680) / 64'd5271360;
      end else begin
         seg   = int'(code >> 4);
         nxt   = (seg < 255) ? seg + 1 : 255;
         lo_pt = srgb_curve[seg];
         hi_pt = srgb_curve[nxt];
         span  = (hi_pt >= lo_pt) ? hi_pt - lo_pt : 64'd0;
         lin   = lo_pt + ((span * 64'(code & 12'd15) + 64'd8) >> 4);
      end
      return FIELD_W'((lin * ((64'd1 << OUT_W) - 64'd1) + (64'd1 << 29)) >> 30);
   endfunction

   function automatic linear_rgb_type predict_pixel(input logic [7:0] y, cb, cr);
      int             base;
      int             u;
      int             v;
      linear_rgb_type rgb;
      base      = int'(y) * 4096;
      u         = int'(cb) - 128;
      v         = int'(cr) - 128;
      rgb.red   = decode_level(gamma_code(base + 6450 * v));
      rgb.green = decode_level(gamma_code(base - 767 * u - 1917 * v));
      rgb.blue  = decode_level(gamma_code(base + 7601 * u));
      return rgb;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   function automatic void check_field(input string name,
                                       input logic [FIELD_W-1:0] want, got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      linear_rgb_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rgb.push_back(predict_pixel(req_luma, req_chroma_blue, req_chroma_red));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no request pending, actual %0d %0d %0d", $time,
                        rsp_red_linear, rsp_green_linear, rsp_blue_linear);
            end else begin
               want = expected_rgb.pop_front();
               check_field("red_linear", want.red, rsp_red_linear);
               check_field("green_linear", want.green, rsp_green_linear);
               check_field("blue_linear", want.blue, rsp_blue_linear);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : result_sink
      int stall;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   end

   task automatic send_pixel(input logic [7:0] y, cb, cr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_luma        <= y;
      req_chroma_blue <= cb;
      req_chroma_red  <= cr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_pixel();
      int shape;
      int spread;
      shape = $urandom_range(9);
      if (shape < 5) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (shape < 8) begin
         spread = $urandom_range(24);
         send_pixel(8'($urandom), 8'(128 - spread + $urandom_range(2 * spread)),
                    8'(128 - spread + $urandom_range(2 * spread)));
      end else begin
         send_pixel(8'($urandom), 8'd128, 8'd128);
      end
   endtask

   task automatic test_directed_corners();
      send_pixel(8'd0, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd128, 8'd128);
      send_pixel(8'd254, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd128, 8'd128);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd0, 8'd128);
      send_pixel(8'd128, 8'd255, 8'd128);
      send_pixel(8'd128, 8'd128, 8'd0);
      send_pixel(8'd128, 8'd128, 8'd255);
      send_pixel(8'd4, 8'd128, 8'd132);
      send_pixel(8'd10, 8'd126, 8'd128);
      send_pixel(8'd10, 8'd128, 8'd128);
      send_pixel(8'd11, 8'd128, 8'd128);
      send_pixel(8'd0, 8'd127, 8'd129);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd85);
   endtask

   task automatic test_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            no_idle = ($urandom_range(3) == 0);
         end
         send_random_pixel();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      hold_pending = 1'b1;
      no_idle = 1'b1;
      for (int i = 0; i < 60; i++) begin
         send_random_pixel();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < 256; k++) begin
         srgb_curve[k] = curve_point(k);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_pixels(RANDOM_PIXELS / 2);
      test_output_backpressure();
      test_random_pixels(RANDOM_PIXELS / 2);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
